FILE: rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Operation codes and shared control types of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  // operation codes on the func field
  typedef enum logic [3:0] {
    FN_ADD    = 4'd0,
    FN_SUB    = 4'd1,
    FN_MUL    = 4'd2,
    FN_DIV    = 4'd3,
    FN_INC    = 4'd4,
    FN_DEC    = 4'd5,
    FN_MIN    = 4'd6,
    FN_MAX    = 4'd7,
    FN_TO_INT = 4'd8
  } func_e;

  // how the back end treats an item
  typedef enum logic [1:0] {
    K_SIMPLE = 2'd0,
    K_MUL    = 2'd1,
    K_DIV    = 2'd2
  } kind_e;

  // classification that travels with an item from front to back
  typedef struct packed {
    kind_e kind;
    logic  neg;      // result sign for mul / div
    logic  dz;       // division by zero
    logic  less;
    logic  equal;
    logic  greater;
  } ctrl_t;

endpackage

FILE: rtl/fpa_if.sv
// ----------------------------------------------------------------------------
// fpa_if
// Valid/ready channels of the fixed-point ALU: operation in, result out.
// ----------------------------------------------------------------------------
interface fpa_in_if #(
  parameter int WORD_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic [3:0]                   func;
  logic signed [WORD_WIDTH-1:0] operand_a;
  logic signed [WORD_WIDTH-1:0] operand_b;

  modport source (output valid, output func, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input func, input operand_a, input operand_b,
                  output ready);
endinterface

interface fpa_out_if #(
  parameter int WORD_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] result;
  logic                         less;
  logic                         equal;
  logic                         greater;
  logic                         overflow;
  logic                         div_by_zero;

  modport source (output valid, output result, output less, output equal,
                  output greater, output overflow, output div_by_zero,
                  input ready);
  modport sink   (input valid, input result, input less, input equal,
                  input greater, input overflow, input div_by_zero,
                  output ready);
endinterface

FILE: rtl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed fixed-point ALU (WORD_WIDTH bits, FRAC_BITS fraction bits). It takes
// one item per cycle unless a result waits at the output, and returns one
// result per item, in order. Every item runs through the same execution
// pipeline, whose length is set by the divider, one quotient bit per stage:
// an item leaves the two-entry input queue and passes the step stages, the
// rounding register and the output register. Default format Q24.8. Multiply
// and divide round half away from zero and saturate; add and subtract wrap.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  fpa_in_if.sink   in_i,
  fpa_out_if.source out_o
);

  localparam int QW = $bits(fpa_pkg::ctrl_t) + 3 * WORD_WIDTH;

  fpa_pkg::ctrl_t          f_ctrl, b_ctrl;
  logic [WORD_WIDTH-1:0]   f_ma, f_mb, f_simple, b_ma, b_mb, b_simple;
  logic                    q_valid, q_ready;
  logic [WORD_WIDTH-1:0]   res;

  // classify
  fpa_front #(
    .WORD_WIDTH (WORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .func_i   (in_i.func),
    .a_i      (in_i.operand_a),
    .b_i      (in_i.operand_b),
    .ctrl_o   (f_ctrl),
    .ma_o     (f_ma),
    .mb_o     (f_mb),
    .simple_o (f_simple)
  );

  // decouple
  fpa_queue #(
    .DATA_WIDTH (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_i.valid),
    .push_ready_o (in_i.ready),
    .push_data_i  ({f_ctrl, f_ma, f_mb, f_simple}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   ({b_ctrl, b_ma, b_mb, b_simple})
  );

  // execute
  fpa_back #(
    .WORD_WIDTH (WORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (q_valid),
    .in_ready_o    (q_ready),
    .ctrl_i        (b_ctrl),
    .ma_i          (b_ma),
    .mb_i          (b_mb),
    .simple_i      (b_simple),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .result_o      (res),
    .less_o        (out_o.less),
    .equal_o       (out_o.equal),
    .greater_o     (out_o.greater),
    .overflow_o    (out_o.overflow),
    .div_by_zero_o (out_o.div_by_zero)
  );

  assign out_o.result = $signed(res);

endmodule

FILE: rtl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// Classifies an item: comparison flags, operand magnitudes, and the full
// result of every operation that needs no multiply or divide, and of a division by zero.
// ----------------------------------------------------------------------------
module fpa_front #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic [3:0]            func_i,
  input  logic [WORD_WIDTH-1:0] a_i,
  input  logic [WORD_WIDTH-1:0] b_i,
  output fpa_pkg::ctrl_t        ctrl_o,
  output logic [WORD_WIDTH-1:0] ma_o,
  output logic [WORD_WIDTH-1:0] mb_o,
  output logic [WORD_WIDTH-1:0] simple_o
);

  localparam logic [WORD_WIDTH-1:0] WMAXP = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam logic [WORD_WIDTH-1:0] WMAXN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  logic                  a_neg, b_neg, lt, eq, gt;
  logic [WORD_WIDTH-1:0] ma, mb, mint;

  // signs, magnitudes, signed compare
  always_comb begin
    a_neg = a_i[WORD_WIDTH-1];
    b_neg = b_i[WORD_WIDTH-1];
    ma    = a_neg ? (~a_i + 1'b1) : a_i;
    mb    = b_neg ? (~b_i + 1'b1) : b_i;
    lt    = $signed(a_i) < $signed(b_i);
    gt    = $signed(a_i) > $signed(b_i);
    eq    = a_i == b_i;
    mint  = ma >> FRAC_BITS;
  end

  // operation decode
  always_comb begin
    ctrl_o.kind    = fpa_pkg::K_SIMPLE;
    ctrl_o.neg     = a_neg ^ b_neg;
    ctrl_o.dz      = 1'b0;
    ctrl_o.less    = lt;
    ctrl_o.equal   = eq;
    ctrl_o.greater = gt;
    simple_o       = '0;
    unique case (fpa_pkg::func_e'(func_i))
      fpa_pkg::FN_ADD:    simple_o = a_i + b_i;
      fpa_pkg::FN_SUB:    simple_o = a_i - b_i;
      fpa_pkg::FN_INC:    simple_o = a_i + 1'b1;
      fpa_pkg::FN_DEC:    simple_o = a_i - 1'b1;
      fpa_pkg::FN_MIN:    simple_o = lt ? a_i : b_i;
      fpa_pkg::FN_MAX:    simple_o = gt ? a_i : b_i;
      fpa_pkg::FN_TO_INT: simple_o = a_neg ? (~mint + 1'b1) : mint;
      fpa_pkg::FN_MUL:    ctrl_o.kind = fpa_pkg::K_MUL;
      fpa_pkg::FN_DIV: begin
        if (b_i == '0) begin
          ctrl_o.dz = 1'b1;
          simple_o  = a_neg ? WMAXN : WMAXP;
        end else begin
          ctrl_o.kind = fpa_pkg::K_DIV;
        end
      end
      default: simple_o = '0;
    endcase
    ma_o = ma;
    mb_o = mb;
  end

endmodule

FILE: rtl/fpa_queue.sv
// ----------------------------------------------------------------------------
// fpa_queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module fpa_queue #(
  parameter int DATA_WIDTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  logic [DATA_WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output logic [DATA_WIDTH-1:0] pop_data_o
);

  logic [DATA_WIDTH-1:0] mem_q [2];
  logic                  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]            count_q, count_d;
  logic                  push, pop;

  always_comb begin
    push_ready_o = count_q != 2'd2;
    pop_valid_o  = count_q != 2'd0;
    pop_data_o   = mem_q[rd_ptr_q];
    push         = push_valid_i & push_ready_o;
    pop          = pop_valid_o & pop_ready_i;
    wr_ptr_d     = wr_ptr_q ^ push;
    rd_ptr_d     = rd_ptr_q ^ pop;
    count_d      = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// Execution pipeline: one restoring divide step and one shift-add multiply
// step per stage, then a rounding stage and a saturating output register.
// ----------------------------------------------------------------------------
module fpa_back #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  fpa_pkg::ctrl_t        ctrl_i,
  input  logic [WORD_WIDTH-1:0] ma_i,
  input  logic [WORD_WIDTH-1:0] mb_i,
  input  logic [WORD_WIDTH-1:0] simple_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [WORD_WIDTH-1:0] result_o,
  output logic                  less_o,
  output logic                  equal_o,
  output logic                  greater_o,
  output logic                  overflow_o,
  output logic                  div_by_zero_o
);

  localparam int W  = WORD_WIDTH;
  localparam int NW = WORD_WIDTH + FRAC_BITS;     // dividend / quotient width
  localparam int PW = 2 * WORD_WIDTH;             // product width
  localparam int XW = (PW > NW ? PW : NW) + 1;    // rounded magnitude width
  localparam int NS = NW;                         // step stages

  localparam logic [W-1:0]  WMAXP = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  WMAXN = {1'b1, {(W-1){1'b0}}};
  localparam logic [XW-1:0] LIMP  = XW'(WMAXP);
  localparam logic [XW-1:0] LIMN  = XW'(WMAXN);
  localparam logic [XW-1:0] HALF  = (XW'(1) << FRAC_BITS) >> 1;

  typedef struct packed {
    fpa_pkg::ctrl_t ctrl;
    logic [W-1:0]   simple;
    logic [W-1:0]   d;
    logic [NW-1:0]  num;
    logic [W:0]     rem;
    logic [NW-1:0]  q;
    logic [PW-1:0]  acc;
    logic [PW-1:0]  mcand;
    logic [W-1:0]   mplier;
  } stage_t;

  typedef struct packed {
    fpa_pkg::ctrl_t ctrl;
    logic [W-1:0]   simple;
    logic [XW-1:0]  mag;
  } round_t;

  // one divide step and one multiply step
  function automatic stage_t step(stage_t s);
    stage_t       r;
    logic [W:0]   rem_sh;
    logic         ge;
    r      = s;
    rem_sh = {s.rem[W-1:0], s.num[NW-1]};
    ge     = rem_sh >= {1'b0, s.d};
    r.rem  = ge ? (rem_sh - {1'b0, s.d}) : rem_sh;
    r.q    = {s.q[NW-2:0], ge};
    r.num  = s.num << 1;
    r.acc  = s.mplier[0] ? (s.acc + s.mcand) : s.acc;
    r.mcand  = s.mcand << 1;
    r.mplier = s.mplier >> 1;
    return r;
  endfunction

  logic           adv;
  stage_t         entry;
  stage_t         st_q [NS];
  logic [NS-1:0]  vld_q;
  round_t         rd_q, rd_d;
  logic           rd_vld_q;
  logic           out_vld_q;
  logic [W-1:0]   result_q, result_d;
  fpa_pkg::ctrl_t octrl_q;
  logic           ovf_q, ovf_d;
  logic           sat;

  // the whole pipe moves unless a finished item waits at the output
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    entry.ctrl   = ctrl_i;
    entry.simple = simple_i;
    entry.d      = mb_i;
    entry.num    = NW'(ma_i) << FRAC_BITS;
    entry.rem    = '0;
    entry.q      = '0;
    entry.acc    = '0;
    entry.mcand  = PW'(ma_i);
    entry.mplier = mb_i;
  end

  // step stages
  for (genvar k = 0; k < NS; k++) begin : g_step
    stage_t src;
    logic   src_vld;
    if (k == 0) begin : g_first
      assign src     = entry;
      assign src_vld = in_valid_i;
    end else begin : g_next
      assign src     = st_q[k-1];
      assign src_vld = vld_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv) begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[k] <= step(src);
      end
    end
  end

  // rounding: half away from zero on the magnitude
  always_comb begin
    rd_d.ctrl   = st_q[NS-1].ctrl;
    rd_d.simple = st_q[NS-1].simple;
    if (st_q[NS-1].ctrl.kind == fpa_pkg::K_DIV) begin
      rd_d.mag = XW'(st_q[NS-1].q) +
                 XW'({st_q[NS-1].rem, 1'b0} >= {2'b00, st_q[NS-1].d});
    end else begin
      rd_d.mag = (XW'(st_q[NS-1].acc) + HALF) >> FRAC_BITS;
    end
  end

  // saturation and result select
  always_comb begin
    sat      = rd_q.mag > (rd_q.ctrl.neg ? LIMN : LIMP);
    result_d = rd_q.simple;
    ovf_d    = 1'b0;
    if (rd_q.ctrl.kind != fpa_pkg::K_SIMPLE) begin
      ovf_d = sat;
      if (sat) begin
        result_d = rd_q.ctrl.neg ? WMAXN : WMAXP;
      end else begin
        result_d = rd_q.ctrl.neg ? (~rd_q.mag[W-1:0] + 1'b1) : rd_q.mag[W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      rd_vld_q  <= vld_q[NS-1];
      out_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_q     <= rd_d;
      result_q <= result_d;
      octrl_q  <= rd_q.ctrl;
      ovf_q    <= ovf_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign result_o      = result_q;
  assign less_o        = octrl_q.less;
  assign equal_o       = octrl_q.equal;
  assign greater_o     = octrl_q.greater;
  assign overflow_o    = ovf_q;
  assign div_by_zero_o = octrl_q.dz;

endmodule

FILE: rtl/fpa_checker.sv
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks on the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
module fpa_checker #(
  parameter int WORD_WIDTH = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [WORD_WIDTH-1:0] result_i,
  input logic                  less_i,
  input logic                  equal_i,
  input logic                  greater_i,
  input logic                  overflow_i,
  input logic                  div_by_zero_i
);

  localparam logic [WORD_WIDTH-1:0] WMAXP = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam logic [WORD_WIDTH-1:0] WMAXN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_i))
    else $error("result changed while stalled");

  // exactly one comparison flag
  a_cmp_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot({less_i, equal_i, greater_i}))
    else $error("comparison flags not one-hot");

  // a zero divisor never also reports saturation
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(overflow_i && div_by_zero_i))
    else $error("overflow and div_by_zero together");

  // saturated and zero-divisor results sit at a word limit
  a_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (overflow_i || div_by_zero_i) |->
      result_i == WMAXP || result_i == WMAXN)
    else $error("saturated result off the word limits");

endmodule

bind fixed_point_alu fpa_checker #(
  .WORD_WIDTH (WORD_WIDTH)
) u_fpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .result_i      (out_o.result),
  .less_i        (out_o.less),
  .equal_i       (out_o.equal),
  .greater_i     (out_o.greater),
  .overflow_i    (out_o.overflow),
  .div_by_zero_i (out_o.div_by_zero)
);
